>>> src/alpha_blit_fill_engine_defines.svh
// ---------------------------------------------------------------------------
// alpha_blit_fill_engine_defines.svh
// Assertion macros shared by the alpha blit / fill engine.
// ---------------------------------------------------------------------------
`ifndef ALPHA_BLIT_FILL_ENGINE_DEFINES_SVH
`define ALPHA_BLIT_FILL_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ABFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ABFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/abfe_pkg.sv
// ---------------------------------------------------------------------------
// abfe_pkg
// Types, constants and pixel math for the alpha blit / fill engine.
// ---------------------------------------------------------------------------
`default_nettype none

package abfe_pkg;

	// Frame store depth default
	localparam int ABFE_FRAME_PIXELS = 65536;

	// Linear index before the store range check: 9-bit column plus 9x9-bit row product
	localparam int IDX_W = 18;

	// Result queue sizing (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
	localparam logic [7:0]  CHAN_MAX     = 8'd255;

	typedef enum logic [1:0] {
		FUNC_BLEND = 2'd0,
		FUNC_FILL  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CFG_SRC_ORG_X  = 3'd0,
		CFG_SRC_ORG_Y  = 3'd1,
		CFG_SRC_WIDTH  = 3'd2,
		CFG_SRC_HEIGHT = 3'd3,
		CFG_DST_ORG_X  = 3'd4,
		CFG_DST_ORG_Y  = 3'd5,
		CFG_DST_WIDTH  = 3'd6,
		CFG_DST_HEIGHT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		func_t       func;
		logic [11:0] off_x;
		logic [11:0] off_y;
		logic [31:0] pixel;
		logic [15:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic        written;
		logic        clipped;
		logic [15:0] index_out;
		logic [31:0] pixel_out;
	} out_item_t;

	typedef struct packed {
		logic signed [12:0] src_org_x;
		logic signed [12:0] src_org_y;
		logic [12:0]        src_width;
		logic [12:0]        src_height;
		logic signed [12:0] dst_org_x;
		logic signed [12:0] dst_org_y;
		logic [8:0]         dst_width;
		logic [8:0]         dst_height;
	} cfg_t;

	// Item entering the read-modify-write stage
	typedef struct packed {
		logic             valid;
		func_t            func;
		logic             ok;
		logic [IDX_W-1:0] idx;
		logic [31:0]      pixel;
	} stage_t;

	// Frame store read request
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} rdreq_t;

	// floor((s*a + d*(255-a)) / 255), exact for sums below 2^16
	function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		logic [15:0] sum;
		logic [16:0] t;
		sum = {8'd0, s} * {8'd0, a} + {8'd0, d} * {8'd0, CHAN_MAX - a};
		t   = {1'b0, sum} + {9'd0, sum[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [31:0] blend_px(input logic [31:0] src, input logic [31:0] dst);
		return {ALPHA_OPAQUE[31:24],
			mix_chan(src[23:16], dst[23:16], src[31:24]),
			mix_chan(src[15:8],  dst[15:8],  src[31:24]),
			mix_chan(src[7:0],   dst[7:0],   src[31:24])};
	endfunction

endpackage

`default_nettype wire

>>> src/alpha_blit_fill_engine.sv
// ---------------------------------------------------------------------------
// alpha_blit_fill_engine
// Clipped ARGB8888 alpha blit and fill engine with an internal frame store.
// ---------------------------------------------------------------------------
// Each accepted item produces exactly one result, in order. The engine takes
// one item per cycle while in_ready is high: two address stages compute
// the clip tests and the linear index, the frame store (one write port,
// one registered read port) is read in the second stage and written back
// in the next cycle, and the write of the previous item is forwarded so
// back-to-back hits on the same pixel blend correctly. A four-entry result
// queue holds finished results; in_ready drops only while four items are
// accepted and not yet delivered. Stored pixels come up undefined after
// reset; there is no clearing pass. Write the configuration registers only
// while no item is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "alpha_blit_fill_engine_defines.svh"

module alpha_blit_fill_engine
	import abfe_pkg::*;
#(
	parameter int FRAME_PIXELS = ABFE_FRAME_PIXELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item
);

	cfg_t              cfg_q;
	logic [QCNT_W-1:0] out_cnt_q;
	logic              in_fire, out_fire;
	rdreq_t            rdreq;
	stage_t            stage_s2;
	logic              push;
	out_item_t         res;

	assign in_ready = (out_cnt_q < QCNT_W'(QUEUE_DEPTH));
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_org_x  <= '0;
			cfg_q.src_org_y  <= '0;
			cfg_q.src_width  <= '0;
			cfg_q.src_height <= '0;
			cfg_q.dst_org_x  <= '0;
			cfg_q.dst_org_y  <= '0;
			cfg_q.dst_width  <= 9'd256;
			cfg_q.dst_height <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_ORG_X:  cfg_q.src_org_x  <= cfg_data;
				CFG_SRC_ORG_Y:  cfg_q.src_org_y  <= cfg_data;
				CFG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data;
				CFG_SRC_HEIGHT: cfg_q.src_height <= cfg_data;
				CFG_DST_ORG_X:  cfg_q.dst_org_x  <= cfg_data;
				CFG_DST_ORG_Y:  cfg_q.dst_org_y  <= cfg_data;
				CFG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[8:0];
				CFG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[8:0];
			endcase
		end
	end

	// Track items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (in_fire && !out_fire) begin
			out_cnt_q <= out_cnt_q + QCNT_W'(1);
		end else if (!in_fire && out_fire) begin
			out_cnt_q <= out_cnt_q - QCNT_W'(1);
		end
	end

	abfe_addr #(
		.FRAME_PIXELS(FRAME_PIXELS)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.rdreq    (rdreq),
		.stage_s2 (stage_s2)
	);

	abfe_store #(
		.FRAME_PIXELS(FRAME_PIXELS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rdreq    (rdreq),
		.stage_s2 (stage_s2),
		.push     (push),
		.res      (res)
	);

	abfe_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (res),
		.pop       (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// Checks
	`ABFE_ASSERT_NOW(a_cnt_bound, 1'b1, out_cnt_q <= QCNT_W'(QUEUE_DEPTH), "too many outstanding")
	`ABFE_ASSERT_NOW(a_valid_owed, out_valid, out_cnt_q != '0, "result with none outstanding")
	`ABFE_ASSERT_NOW(a_write_unclipped, out_valid, !(out_item.written && out_item.clipped), "both")
	`ABFE_ASSERT_NEXT(a_cnt_inc, in_fire && !out_fire, out_cnt_q == $past(out_cnt_q) + QCNT_W'(1), "miss")

endmodule

`default_nettype wire

>>> src/abfe_addr.sv
// ---------------------------------------------------------------------------
// abfe_addr
// Clip checks and frame store index, two pipeline stages; issues the read.
// ---------------------------------------------------------------------------
`default_nettype none

module abfe_addr
	import abfe_pkg::*;
#(
	parameter int FRAME_PIXELS = ABFE_FRAME_PIXELS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_fire,
	input  wire in_item_t in_item,
	input  wire cfg_t     cfg,
	output rdreq_t        rdreq,
	output stage_t        stage_s2
);

	logic [13:0] dxo, dyo, sxi, syi;
	logic        dst_in, src_in, inside_c;
	logic [IDX_W-1:0] prod_c;

	logic        valid_s1;
	func_t       func_s1;
	logic        inside_s1;
	logic [8:0]  xo_s1;
	logic [IDX_W-1:0] prod_s1;
	logic [31:0] pixel_s1;
	logic [15:0] ridx_s1;

	logic [IDX_W-1:0] idx_c;
	logic        in_range_c, ok_c;

	logic             valid_s2;
	func_t            func_s2;
	logic             ok_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [31:0]      pixel_s2;

	// Stage 1: surface coordinates, clip tests, row offset product
	always_comb begin
		dxo = {cfg.dst_org_x[12], cfg.dst_org_x} + {2'b00, in_item.off_x};
		dyo = {cfg.dst_org_y[12], cfg.dst_org_y} + {2'b00, in_item.off_y};
		sxi = {cfg.src_org_x[12], cfg.src_org_x} + {2'b00, in_item.off_x};
		syi = {cfg.src_org_y[12], cfg.src_org_y} + {2'b00, in_item.off_y};
		dst_in = !dxo[13] && (dxo[12:0] < {4'd0, cfg.dst_width}) &&
			!dyo[13] && (dyo[12:0] < {4'd0, cfg.dst_height});
		src_in = !sxi[13] && (sxi[12:0] < cfg.src_width) &&
			!syi[13] && (syi[12:0] < cfg.src_height);
		inside_c = dst_in && (in_item.func != FUNC_BLEND || src_in);
		// Row below the 9-bit height whenever inside, so nine bits are enough
		prod_c = {9'd0, dyo[8:0]} * {9'd0, cfg.dst_width};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		func_s1   <= in_item.func;
		inside_s1 <= inside_c;
		xo_s1     <= dxo[8:0];
		prod_s1   <= prod_c;
		pixel_s1  <= in_item.pixel;
		ridx_s1   <= in_item.read_index;
	end

	// Stage 2: linear index, store range check, read request
	always_comb begin
		if (func_s1 == FUNC_READ) begin
			idx_c = {2'd0, ridx_s1};
		end else begin
			idx_c = prod_s1 + {9'd0, xo_s1};
		end
		in_range_c = {14'd0, idx_c} < 32'(FRAME_PIXELS);
		unique case (func_s1)
			FUNC_BLEND, FUNC_FILL: ok_c = inside_s1 && in_range_c;
			FUNC_READ:             ok_c = in_range_c;
			FUNC_NONE:             ok_c = 1'b0;
		endcase
		rdreq.en  = valid_s1 && ok_c && (func_s1 == FUNC_READ || func_s1 == FUNC_BLEND);
		rdreq.idx = idx_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2  <= func_s1;
		ok_s2    <= ok_c;
		idx_s2   <= idx_c;
		pixel_s2 <= pixel_s1;
	end

	assign stage_s2 = '{valid: valid_s2, func: func_s2, ok: ok_s2, idx: idx_s2,
		pixel: pixel_s2};

endmodule

`default_nettype wire

>>> src/abfe_store.sv
// ---------------------------------------------------------------------------
// abfe_store
// Frame store memory with read-modify-write, write forwarding and blending.
// ---------------------------------------------------------------------------
`default_nettype none

module abfe_store
	import abfe_pkg::*;
#(
	parameter int FRAME_PIXELS = ABFE_FRAME_PIXELS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire rdreq_t rdreq,
	input  wire stage_t stage_s2,
	output logic        push,
	output out_item_t   res
);

	localparam int AW = $clog2(FRAME_PIXELS);

	logic [31:0] mem [FRAME_PIXELS];
	logic [31:0] rdata_q;

	logic             fwd_en_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [31:0]      fwd_data_q;

	logic [31:0] dst_px, val;
	logic        wr_en;

	// Memory: one write and one registered read per cycle, read returns old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(stage_s2.idx)] <= val;
		end
		if (rdreq.en) begin
			rdata_q <= mem[AW'(rdreq.idx)];
		end
	end

	// Forward the write that landed on the same edge as this item's read
	always_comb begin
		if (fwd_en_q && fwd_idx_q == stage_s2.idx) begin
			dst_px = fwd_data_q;
		end else begin
			dst_px = rdata_q;
		end
	end

	// Compute new pixel and result
	always_comb begin
		val = (stage_s2.func == FUNC_BLEND) ? blend_px(stage_s2.pixel, dst_px) : stage_s2.pixel;
		wr_en = stage_s2.valid && stage_s2.ok &&
			(stage_s2.func == FUNC_BLEND || stage_s2.func == FUNC_FILL);
		push = stage_s2.valid;
		unique case (stage_s2.func)
			FUNC_BLEND, FUNC_FILL: begin
				res.written   = stage_s2.ok;
				res.clipped   = !stage_s2.ok;
				res.index_out = stage_s2.ok ? stage_s2.idx[15:0] : 16'd0;
				res.pixel_out = stage_s2.ok ? val : 32'd0;
			end
			FUNC_READ: begin
				res.written   = 1'b0;
				res.clipped   = !stage_s2.ok;
				res.index_out = stage_s2.idx[15:0];
				res.pixel_out = stage_s2.ok ? dst_px : 32'd0;
			end
			FUNC_NONE: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0;
		end else begin
			fwd_en_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q  <= stage_s2.idx;
		fwd_data_q <= val;
	end

endmodule

`default_nettype wire

>>> src/abfe_outq.sv
// ---------------------------------------------------------------------------
// abfe_outq
// Small result queue that decouples the pipeline from output backpressure.
// ---------------------------------------------------------------------------
`default_nettype none

module abfe_outq
	import abfe_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire out_item_t push_item,
	input  wire logic      pop,
	output logic           out_valid,
	output out_item_t      out_item
);

	out_item_t          entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop_fire;

	assign out_valid = (cnt_q != '0);
	assign out_item  = entries[rd_ptr_q];
	assign pop_fire  = out_valid && pop;

	// Store pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop_fire) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && pop_fire) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/blit_result_checker.sv
// ---------------------------------------------------------------------------
// blit_result_checker
// Watches the configuration port and both item channels of the alpha blit /
// fill engine, keeps a shadow copy of the geometry registers and the frame
// store, works out the result of every accepted item and compares each
// delivered result field by field against the oldest one still due.
// ---------------------------------------------------------------------------
module blit_result_checker
	import abfe_pkg::*;
#(
	parameter int FRAME_PIXELS = ABFE_FRAME_PIXELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire in_item_t    in_item,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire out_item_t   out_item,
	output int               errors,
	output int               pending
);

	// Geometry as currently programmed (reset values)
	int src_ox = 0, src_oy = 0, src_w = 0, src_h = 0;
	int dst_ox = 0, dst_oy = 0, dst_w = 256, dst_h = 256;

	logic [31:0] shadow_store [FRAME_PIXELS];
	out_item_t   due_results [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// floor((s*a + d*(255-a)) / 255) for one colour channel
	function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		int unsigned acc;
		acc = int'(s) * int'(a) + int'(d) * (int'(CHAN_MAX) - int'(a));
		return 8'(acc / 255);
	endfunction

	// Apply one item to the shadow store and return the result it yields
	function automatic out_item_t apply_item(input in_item_t it);
		out_item_t   r;
		int          xo, yo, xi, yi, idx;
		bit          hit;
		logic [31:0] old, val;
		r = '0;
		case (it.func)
		FUNC_READ: begin
			r.index_out = it.read_index;
			if (int'(it.read_index) < FRAME_PIXELS)
				r.pixel_out = shadow_store[it.read_index];
			else
				r.clipped = 1'b1;
		end
		FUNC_BLEND, FUNC_FILL: begin
			xo  = dst_ox + int'(it.off_x);
			yo  = dst_oy + int'(it.off_y);
			hit = xo >= 0 && yo >= 0 && xo < dst_w && yo < dst_h;
			if (it.func == FUNC_BLEND) begin
				xi = src_ox + int'(it.off_x);
				yi = src_oy + int'(it.off_y);
				if (!(xi >= 0 && yi >= 0 && xi < src_w && yi < src_h))
					hit = 1'b0;
			end
			idx = xo + yo * dst_w;
			if (hit && idx >= FRAME_PIXELS)
				hit = 1'b0;
			if (!hit) begin
				r.clipped = 1'b1;
			end else begin
				old = shadow_store[idx];
				if (it.func == FUNC_BLEND)
					val = {ALPHA_OPAQUE[31:24],
						mix_channel(it.pixel[23:16], old[23:16], it.pixel[31:24]),
						mix_channel(it.pixel[15:8], old[15:8], it.pixel[31:24]),
						mix_channel(it.pixel[7:0], old[7:0], it.pixel[31:24])};
				else
					val = it.pixel;
				shadow_store[idx] = val;
				r.written   = 1'b1;
				r.index_out = idx[15:0];
				r.pixel_out = val;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
	endtask

	// Track register writes, queue predictions, compare delivered results
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
				CFG_SRC_ORG_X:  src_ox = int'($signed(cfg_data));
				CFG_SRC_ORG_Y:  src_oy = int'($signed(cfg_data));
				CFG_SRC_WIDTH:  src_w  = int'(cfg_data);
				CFG_SRC_HEIGHT: src_h  = int'(cfg_data);
				CFG_DST_ORG_X:  dst_ox = int'($signed(cfg_data));
				CFG_DST_ORG_Y:  dst_oy = int'($signed(cfg_data));
				CFG_DST_WIDTH:  dst_w  = int'(cfg_data[8:0]);
				CFG_DST_HEIGHT: dst_h  = int'(cfg_data[8:0]);
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_results.push_back(apply_item(in_item));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got %p", $time, out_item);
				end else begin
					want = due_results.pop_front();
					if (out_item.written !== want.written)
						report_field("written", 32'(want.written), 32'(out_item.written));
					if (out_item.clipped !== want.clipped)
						report_field("clipped", 32'(want.clipped), 32'(out_item.clipped));
					if (out_item.index_out !== want.index_out)
						report_field("index_out", 32'(want.index_out),
							32'(out_item.index_out));
					if (out_item.pixel_out !== want.pixel_out)
						report_field("pixel_out", want.pixel_out, out_item.pixel_out);
				end
			end
			pending = due_results.size();
		end
	end

endmodule

>>> tb/alpha_blit_fill_engine_tb.sv
// ---------------------------------------------------------------------------
// alpha_blit_fill_engine_tb
// Drives the alpha blit / fill engine through a directed opening and a run
// of random phases under changing geometry and flow-control pressure; the
// result checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module alpha_blit_fill_engine_tb;
	import abfe_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = CFG_SRC_ORG_X;
	logic [12:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	in_item_t    in_item   = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	out_item_t   out_item;
	int          errors;
	int          pending;

	idle_mode_t idle_mode  = IDLE_NONE;
	bit         hold_req   = 1'b0;
	bit         hold_taken = 1'b0;
	int         hold_cnt   = 0;
	int         stall_cycles = 0;

	// Geometry as programmed, for steering items onto the surfaces
	int s_ox = 0, s_oy = 0, s_w = 0, s_h = 0;
	int d_ox = 0, d_oy = 0, d_w = 256, d_h = 256;

	// Store entries written so far; reads and blends touch only these
	bit painted [ABFE_FRAME_PIXELS];
	int painted_list [$];

	alpha_blit_fill_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	blit_result_checker results (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.errors    (errors),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	// Drive receiver ready: one long hold-off on request, random stalls in the receiver-idle modes, else always ready
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cnt   <= HOLD_CYCLES;
			out_ready  <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (idle_mode == IDLE_RECV) begin
			out_ready <= $urandom_range(99) >= 70;
		end else if (idle_mode == IDLE_BOTH) begin
			out_ready <= $urandom_range(99) >= 20;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("alpha_blit_fill_engine_tb: errors");
				$finish;
			end
		end
	end

	function automatic int rand_span(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic bit sender_idle();
		if (idle_mode == IDLE_SEND)
			return $urandom_range(99) < 70;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(99) < 20;
		return 1'b0;
	endfunction

	// Store index an item lands on, or -1 when it is clipped
	function automatic int target(input in_item_t it);
		int xo, yo, xi, yi, idx;
		xo = d_ox + int'(it.off_x);
		yo = d_oy + int'(it.off_y);
		if (xo < 0 || yo < 0 || xo >= d_w || yo >= d_h)
			return -1;
		if (it.func == FUNC_BLEND) begin
			xi = s_ox + int'(it.off_x);
			yi = s_oy + int'(it.off_y);
			if (xi < 0 || yi < 0 || xi >= s_w || yi >= s_h)
				return -1;
		end
		idx = xo + yo * d_w;
		return (idx < ABFE_FRAME_PIXELS) ? idx : -1;
	endfunction

	// Offset that lands inside the destination (and source, for blends)
	function automatic logic [11:0] pick_off(input int dorg, input int dsize, input int sorg,
		input int ssize, input bit with_src, input logic [11:0] fallback);
		int lo, hi;
		lo = -dorg;
		hi = dsize - 1 - dorg;
		if (with_src) begin
			if (-sorg > lo)
				lo = -sorg;
			if (ssize - 1 - sorg < hi)
				hi = ssize - 1 - sorg;
		end
		if (lo < 0)
			lo = 0;
		if (hi > 4095)
			hi = 4095;
		if (lo > hi)
			return fallback;
		return 12'($urandom_range(hi, lo));
	endfunction

	function automatic in_item_t make_item(input func_t f, input int ox, input int oy,
		input logic [31:0] px, input int ri);
		in_item_t it;
		it.func       = f;
		it.off_x      = ox[11:0];
		it.off_y      = oy[11:0];
		it.pixel      = px;
		it.read_index = ri[15:0];
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		it.off_x      = 12'($urandom);
		it.off_y      = 12'($urandom);
		it.pixel      = $urandom;
		it.read_index = 16'($urandom);
		r = $urandom_range(99);
		if (r < 35)
			it.func = FUNC_BLEND;
		else if (r < 70)
			it.func = FUNC_FILL;
		else if (r < 95)
			it.func = FUNC_READ;
		else
			it.func = FUNC_NONE;
		r = $urandom_range(9);
		if (r == 0)
			it.pixel[31:24] = 8'h00;
		else if (r == 1)
			it.pixel[31:24] = 8'hFF;
		// Steer most items onto the surfaces
		if ($urandom_range(99) < 85) begin
			it.off_x = pick_off(d_ox, d_w, s_ox, s_w, it.func == FUNC_BLEND, it.off_x);
			it.off_y = pick_off(d_oy, d_h, s_oy, s_h, it.func == FUNC_BLEND, it.off_y);
		end
		return it;
	endfunction

	// Keep the item off unwritten entries, then offer it until accepted
	task automatic push(input in_item_t it);
		int idx;
		if (it.func == FUNC_READ && !painted[it.read_index]) begin
			if (painted_list.size() != 0)
				it.read_index = painted_list[$urandom_range(painted_list.size() - 1)];
			else
				it.func = FUNC_NONE;
		end
		idx = -1;
		if (it.func == FUNC_BLEND || it.func == FUNC_FILL)
			idx = target(it);
		if (it.func == FUNC_BLEND && idx >= 0 && !painted[idx])
			it.func = FUNC_FILL;
		if (idx >= 0 && !painted[idx]) begin
			painted[idx] = 1'b1;
			painted_list.push_back(idx);
		end
		while (sender_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold the sender until every result has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[12:0];
		@(posedge clk);
	endtask

	task automatic set_geometry(input int sox, input int soy, input int sw, input int sh,
		input int dox, input int doy, input int dw, input int dh);
		wait_drain();
		write_reg(CFG_SRC_ORG_X, sox);
		write_reg(CFG_SRC_ORG_Y, soy);
		write_reg(CFG_SRC_WIDTH, sw);
		write_reg(CFG_SRC_HEIGHT, sh);
		write_reg(CFG_DST_ORG_X, dox);
		write_reg(CFG_DST_ORG_Y, doy);
		write_reg(CFG_DST_WIDTH, dw);
		write_reg(CFG_DST_HEIGHT, dh);
		cfg_we <= 1'b0;
		s_ox = sox; s_oy = soy; s_w = sw; s_h = sh;
		d_ox = dox; d_oy = doy; d_w = dw; d_h = dh;
	endtask

	task automatic run_phase(input idle_mode_t mode, input int count);
		idle_mode = mode;
		repeat (count) push(random_item());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: empty source, full 256x256 store
		push(make_item(FUNC_NONE, 4095, 4095, 32'hFFFF_FFFF, 65535));
		push(make_item(FUNC_FILL, 0, 0, 32'h0000_0000, 0));
		push(make_item(FUNC_FILL, 255, 255, 32'hFFFF_FFFF, 0));
		push(make_item(FUNC_FILL, 4095, 4095, 32'h1234_5678, 0));
		push(make_item(FUNC_FILL, 256, 0, 32'h1234_5678, 0));
		push(make_item(FUNC_BLEND, 0, 0, 32'hFF00_0000, 0));
		push(make_item(FUNC_READ, 0, 0, 32'h0, 0));
		push(make_item(FUNC_READ, 0, 0, 32'h0, 65535));

		// Source shifted left: blends at small x clip on the source only
		set_geometry(-10, 0, 300, 300, 0, 0, 256, 256);
		push(make_item(FUNC_FILL, 10, 0, 32'h00FF_8040, 0));
		push(make_item(FUNC_BLEND, 10, 0, 32'h0012_3456, 0));
		push(make_item(FUNC_BLEND, 10, 0, 32'hFF00_FF00, 0));
		push(make_item(FUNC_BLEND, 10, 0, 32'h80FF_FFFF, 0));
		push(make_item(FUNC_BLEND, 10, 0, 32'h7F00_0000, 0));
		push(make_item(FUNC_BLEND, 0, 0, 32'hFFFF_FFFF, 0));
		push(make_item(FUNC_BLEND, 10, 300, 32'hFFFF_FFFF, 0));
		push(make_item(FUNC_READ, 0, 0, 32'h0, 10));
		push(make_item(FUNC_NONE, 0, 0, 32'h0, 0));

		// Small window, then a long receiver hold-off while items pile up
		set_geometry(0, 0, 16, 16, 0, 0, 16, 16);
		run_phase(IDLE_NONE, 40);
		hold_req <= 1'b1;
		run_phase(IDLE_NONE, 60);

		// Extreme origins: every blend and fill clips
		set_geometry(-4096, -4096, 4096, 4096, 4095, 4095, 256, 256);
		run_phase(IDLE_BOTH, 30);

		// Deep offsets over the whole store
		set_geometry(0, 0, 4096, 4096, -4000, -3900, 256, 256);
		run_phase(IDLE_SEND, 120);

		// Empty destination
		set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
		run_phase(IDLE_RECV, 20);

		// Single pixel: back-to-back blends on one entry
		set_geometry(3, 3, 10, 10, 0, 0, 1, 1);
		run_phase(IDLE_NONE, 80);

		// Random geometries, mostly small windows
		for (int p = 0; p < 8; p++) begin
			set_geometry(rand_span(-20, 20), rand_span(-20, 20), rand_span(0, 40),
				rand_span(0, 40), rand_span(-20, 20), rand_span(-20, 20),
				($urandom_range(7) == 0) ? 256 : rand_span(1, 24), rand_span(1, 24));
			run_phase(idle_mode_t'(p % 4), 80);
		end

		wait_drain();
		if (errors == 0 && pending == 0)
			$display("alpha_blit_fill_engine_tb: clean");
		else
			$display("alpha_blit_fill_engine_tb: errors");
		$finish;
	end

endmodule
